>>> src/cbb_pkg.sv
// shared types and constants for the cubic bezier box pipeline
// no dependencies; used by every module of the block
package cbb_pkg;

  // pipeline control that runs beside every payload
  typedef struct packed {
    logic en;   // whole pipeline advances
    logic vld;  // item present at the unit input
  } pipe_ctl_t;

  // slice width for the split wide multiplications
  localparam int CHUNK_BITS = 16;

endpackage

>>> src/cbb_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on cbb_pkg for the pipeline control struct
module cbb_isqrt #(
  parameter int IW = 52,
  parameter int SW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbb_pkg::pipe_ctl_t  ctl_i,
  input  logic [IW-1:0]       rad_i,
  input  logic [SW-1:0]       side_i,
  output logic                vld_o,
  output logic [IW/2-1:0]     root_o,
  output logic [SW-1:0]       side_o
);

  localparam int N  = IW / 2;
  localparam int MW = N + 2;

  logic [N-1:0]  v_q;
  logic [IW-1:0] x_q  [N];
  logic [MW-1:0] r_q  [N];
  logic [N-1:0]  rt_q [N];
  logic [SW-1:0] s_q  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic          vin;
    logic [IW-1:0] xin;
    logic [MW-1:0] rin;
    logic [N-1:0]  rtin;
    logic [SW-1:0] sin;
    logic [MW-1:0] rem2;
    logic [MW-1:0] trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign vin  = ctl_i.vld;
      assign xin  = rad_i;
      assign rin  = '0;
      assign rtin = '0;
      assign sin  = side_i;
    end else begin : g_next
      assign vin  = v_q[i-1];
      assign xin  = x_q[i-1];
      assign rin  = r_q[i-1];
      assign rtin = rt_q[i-1];
      assign sin  = s_q[i-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem2  = {rin[MW-3:0], xin[IW-1 -: 2]};
    assign trial = {rtin, 2'b01};
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (ctl_i.en) begin
        v_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        x_q[i]  <= xin << 2;
        r_q[i]  <= ge ? (rem2 - trial) : rem2;
        rt_q[i] <= {rtin[N-2:0], ge};
        s_q[i]  <= sin;
      end
    end
  end

  assign vld_o  = v_q[N-1];
  assign root_o = rt_q[N-1];
  assign side_o = s_q[N-1];

endmodule

>>> src/cbb_div.sv
// pipelined restoring divider for a proper fraction num/den, one quotient bit per stage
// depends on cbb_pkg for the pipeline control struct
module cbb_div #(
  parameter int NW = 27,
  parameter int QW = 24,
  parameter int SW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbb_pkg::pipe_ctl_t  ctl_i,
  input  logic [NW-1:0]       num_i,
  input  logic [NW-1:0]       den_i,
  input  logic [SW-1:0]       side_i,
  output logic                vld_o,
  output logic [QW-1:0]       quo_o,
  output logic [SW-1:0]       side_o
);

  logic [QW-1:0] v_q;
  logic [NW-1:0] r_q [QW];
  logic [NW-1:0] d_q [QW];
  logic [QW-1:0] q_q [QW];
  logic [SW-1:0] s_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          vin;
    logic [NW-1:0] rin;
    logic [NW-1:0] din;
    logic [QW-1:0] qin;
    logic [SW-1:0] sin;
    logic [NW:0]   rem2;
    logic          ge;

    if (i == 0) begin : g_first
      assign vin = ctl_i.vld;
      assign rin = num_i;
      assign din = den_i;
      assign qin = '0;
      assign sin = side_i;
    end else begin : g_next
      assign vin = v_q[i-1];
      assign rin = r_q[i-1];
      assign din = d_q[i-1];
      assign qin = q_q[i-1];
      assign sin = s_q[i-1];
    end

    // remainder stays below the divisor, so it keeps nw bits
    assign rem2 = {rin, 1'b0};
    assign ge   = (rem2 >= {1'b0, din});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (ctl_i.en) begin
        v_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        r_q[i] <= ge ? NW'(rem2 - {1'b0, din}) : NW'(rem2);
        d_q[i] <= din;
        q_q[i] <= {qin[QW-2:0], ge};
        s_q[i] <= sin;
      end
    end
  end

  assign vld_o  = v_q[QW-1];
  assign quo_o  = q_q[QW-1];
  assign side_o = s_q[QW-1];

endmodule

>>> src/cbb_horner.sv
// exact cubic evaluation p0 + 3k0 t + 3k1 t^2 + k2 t^3 by three horner steps
// each step: sliced partial products, then a registered sum; depends on cbb_pkg
module cbb_horner #(
  parameter int C  = 24,
  parameter int F  = 24,
  parameter int SW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cbb_pkg::pipe_ctl_t   ctl_i,
  input  logic signed [C+2:0]  k0_i,
  input  logic signed [C+2:0]  k1_i,
  input  logic signed [C+2:0]  k2_i,
  input  logic signed [C-1:0]  p0_i,
  input  logic [F-1:0]         tq_i,
  input  logic [SW-1:0]        side_i,
  output logic                 vld_o,
  output logic signed [C-1:0]  val_o,
  output logic [SW-1:0]        side_o
);

  localparam int KW  = C + 3;
  localparam int W   = C + 3 * F + 6;
  localparam int CH  = cbb_pkg::CHUNK_BITS;
  localparam int NCH = (W + CH - 1) / CH;
  localparam int XW  = NCH * CH;
  localparam int PPW = CH + F + 2;

  logic [2:0]               va_q;
  logic [2:0]               vb_q;
  logic signed [PPW-1:0]    pp_q  [3][NCH];
  logic signed [W-1:0]      add_q [3];
  logic signed [W-1:0]      acc_q [3];
  logic [F-1:0]             tqa_q [3];
  logic [F-1:0]             tqb_q [3];
  logic signed [KW-1:0]     k0a_q [3];
  logic signed [KW-1:0]     k1a_q [3];
  logic signed [KW-1:0]     k0b_q [3];
  logic signed [KW-1:0]     k1b_q [3];
  logic signed [C-1:0]      p0a_q [3];
  logic signed [C-1:0]      p0b_q [3];
  logic [SW-1:0]            sa_q  [3];
  logic [SW-1:0]            sb_q  [3];

  for (genvar g = 0; g < 3; g++) begin : g_step
    logic                  vin;
    logic signed [W-1:0]   ain;
    logic [F-1:0]          tin;
    logic signed [KW-1:0]  k0in;
    logic signed [KW-1:0]  k1in;
    logic signed [C-1:0]   p0in;
    logic [SW-1:0]         sin;
    logic signed [XW-1:0]  ax;
    logic signed [W-1:0]   add_d;
    logic signed [W-1:0]   sum_d;
    logic signed [W-1:0]   tri_w;
    logic signed [PPW-1:0] pp_d [NCH];

    if (g == 0) begin : g_first
      assign vin  = ctl_i.vld;
      assign ain  = W'(k2_i);
      assign tin  = tq_i;
      assign k0in = k0_i;
      assign k1in = k1_i;
      assign p0in = p0_i;
      assign sin  = side_i;
    end else begin : g_next
      assign vin  = vb_q[g-1];
      assign ain  = acc_q[g-1];
      assign tin  = tqb_q[g-1];
      assign k0in = k0b_q[g-1];
      assign k1in = k1b_q[g-1];
      assign p0in = p0b_q[g-1];
      assign sin  = sb_q[g-1];
    end

    // term added after this step's multiply, aligned to the running scale
    if (g == 0) begin : g_add1
      assign tri_w = W'(k1in);
      assign add_d = ((tri_w <<< 1) + tri_w) <<< F;
    end else if (g == 1) begin : g_add0
      assign tri_w = W'(k0in);
      assign add_d = ((tri_w <<< 1) + tri_w) <<< (2 * F);
    end else begin : g_addp
      assign tri_w = W'(p0in);
      assign add_d = tri_w <<< (3 * F);
    end

    assign ax = XW'(ain);

    // low slices unsigned, top slice carries the sign
    always_comb begin
      for (int j = 0; j < NCH; j++) begin
        if (j == NCH - 1) begin
          pp_d[j] = PPW'($signed(ax[XW-1 -: CH])) * PPW'($signed({1'b0, tin}));
        end else begin
          pp_d[j] = PPW'($signed({1'b0, ax[j*CH +: CH]})) * PPW'($signed({1'b0, tin}));
        end
      end
    end

    always_comb begin
      sum_d = add_q[g];
      for (int j = 0; j < NCH; j++) begin
        sum_d = sum_d + (W'(pp_q[g][j]) <<< (j * CH));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q[g] <= 1'b0;
        vb_q[g] <= 1'b0;
      end else if (ctl_i.en) begin
        va_q[g] <= vin;
        vb_q[g] <= va_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        pp_q[g]  <= pp_d;
        add_q[g] <= add_d;
        tqa_q[g] <= tin;
        k0a_q[g] <= k0in;
        k1a_q[g] <= k1in;
        p0a_q[g] <= p0in;
        sa_q[g]  <= sin;
        acc_q[g] <= sum_d;
        tqb_q[g] <= tqa_q[g];
        k0b_q[g] <= k0a_q[g];
        k1b_q[g] <= k1a_q[g];
        p0b_q[g] <= p0a_q[g];
        sb_q[g]  <= sa_q[g];
      end
    end
  end

  // floor of the q.(3f) result back to the coordinate grid
  assign vld_o  = vb_q[2];
  assign val_o  = $signed(acc_q[2][3*F +: C]);
  assign side_o = sb_q[2];

endmodule

>>> src/cbb_axis.sv
// one axis of the box: coefficients, discriminant, root, two divides, two evaluations
// depends on cbb_pkg, cbb_isqrt, cbb_div and cbb_horner
module cbb_axis #(
  parameter int C = 24,
  parameter int F = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbb_pkg::pipe_ctl_t  ctl_i,
  input  logic signed [C-1:0] p0_i,
  input  logic signed [C-1:0] p1_i,
  input  logic signed [C-1:0] p2_i,
  input  logic signed [C-1:0] p3_i,
  output logic                vld_o,
  output logic signed [C-1:0] mn_o,
  output logic signed [C-1:0] mx_o
);

  localparam int KW   = C + 3;
  localparam int PW   = 2 * KW;
  localparam int IW   = 2 * C + 4;
  localparam int RW   = IW / 2;
  localparam int DW   = C + 4;
  localparam int NW   = C + 3;
  localparam int CTXW = 3 * KW + 3 * C;

  // coefficient stage
  logic signed [KW-1:0] sp0, sp1, sp2, sp3, dif12;
  logic signed [KW-1:0] k0_d, k1_d, k2_d;
  logic                 va_q;
  logic signed [KW-1:0] k0a_q, k1a_q, k2a_q;
  logic signed [C-1:0]  p0a_q, mna_q, mxa_q;

  assign sp0   = KW'(p0_i);
  assign sp1   = KW'(p1_i);
  assign sp2   = KW'(p2_i);
  assign sp3   = KW'(p3_i);
  assign dif12 = sp1 - sp2;
  assign k0_d  = sp1 - sp0;
  assign k1_d  = sp0 - (sp1 <<< 1) + sp2;
  assign k2_d  = sp3 - sp0 + (dif12 <<< 1) + dif12;

  // product stage
  logic                 vb_q;
  logic signed [PW-1:0] sq_q, cr_q;
  logic signed [KW-1:0] k0b_q, k1b_q, k2b_q;
  logic signed [C-1:0]  p0b_q, mnb_q, mxb_q;

  // discriminant stage
  logic signed [PW-1:0] h;
  logic                 hpos;
  logic                 vc_q;
  logic                 hposc_q;
  logic [IW-1:0]        radc_q;
  logic [CTXW-1:0]      ctxc_q;

  assign h    = sq_q - cr_q;
  assign hpos = !h[PW-1] && (h != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (ctl_i.en) begin
      va_q <= ctl_i.vld;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      k0a_q   <= k0_d;
      k1a_q   <= k1_d;
      k2a_q   <= k2_d;
      p0a_q   <= p0_i;
      mna_q   <= (p0_i < p3_i) ? p0_i : p3_i;
      mxa_q   <= (p0_i > p3_i) ? p0_i : p3_i;
      sq_q    <= PW'(k1a_q) * PW'(k1a_q);
      cr_q    <= PW'(k0a_q) * PW'(k2a_q);
      k0b_q   <= k0a_q;
      k1b_q   <= k1a_q;
      k2b_q   <= k2a_q;
      p0b_q   <= p0a_q;
      mnb_q   <= mna_q;
      mxb_q   <= mxa_q;
      hposc_q <= hpos;
      radc_q  <= hpos ? h[IW-1:0] : '0;
      ctxc_q  <= {k0b_q, k1b_q, k2b_q, p0b_q, mnb_q, mxb_q};
    end
  end

  // square root
  cbb_pkg::pipe_ctl_t sq_ctl;
  logic               sq_vld;
  logic [RW-1:0]      root;
  logic [CTXW:0]      sq_side;

  assign sq_ctl = '{en: ctl_i.en, vld: vc_q};

  cbb_isqrt #(
    .IW (IW),
    .SW (CTXW + 1)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sq_ctl),
    .rad_i  (radc_q),
    .side_i ({hposc_q, ctxc_q}),
    .vld_o  (sq_vld),
    .root_o (root),
    .side_o (sq_side)
  );

  // candidate divisors and the exact 0 < t < 1 test
  logic signed [KW-1:0] k0s, k1s;
  logic signed [DW-1:0] negk1, sx, d0, d1;
  logic [NW-1:0]        ak0, ad0, ad1;
  logic                 ok0, ok1;

  assign k0s   = $signed(sq_side[CTXW-1 -: KW]);
  assign k1s   = $signed(sq_side[CTXW-KW-1 -: KW]);
  assign negk1 = -DW'(k1s);
  assign sx    = $signed(DW'(root));
  assign d0    = negk1 - sx;
  assign d1    = negk1 + sx;
  assign ak0   = k0s[KW-1] ? NW'(-k0s) : NW'(k0s);
  assign ad0   = d0[DW-1] ? NW'(-d0) : NW'(d0);
  assign ad1   = d1[DW-1] ? NW'(-d1) : NW'(d1);
  assign ok0   = sq_side[CTXW] && (k0s != '0) && (d0 != '0)
                 && (k0s[KW-1] == d0[DW-1]) && (ak0 < ad0);
  assign ok1   = sq_side[CTXW] && (k0s != '0) && (d1 != '0)
                 && (k0s[KW-1] == d1[DW-1]) && (ak0 < ad1);

  logic            vd_q;
  logic            ok0d_q, ok1d_q;
  logic [NW-1:0]   num0d_q, num1d_q, den0d_q, den1d_q;
  logic [CTXW-1:0] ctxd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (ctl_i.en) begin
      vd_q <= sq_vld;
    end
  end

  // a rejected candidate divides 0 by 1 so the divider stays well defined
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      ok0d_q  <= ok0;
      ok1d_q  <= ok1;
      num0d_q <= ok0 ? ak0 : '0;
      num1d_q <= ok1 ? ak0 : '0;
      den0d_q <= ok0 ? ad0 : NW'(1);
      den1d_q <= ok1 ? ad1 : NW'(1);
      ctxd_q  <= sq_side[CTXW-1:0];
    end
  end

  // parameter t for both candidates
  cbb_pkg::pipe_ctl_t dv_ctl;
  logic               dv_vld;
  logic [F-1:0]       tq0, tq1;
  logic [CTXW:0]      dv0_side;
  logic               dv1_ok;

  assign dv_ctl = '{en: ctl_i.en, vld: vd_q};

  cbb_div #(
    .NW (NW),
    .QW (F),
    .SW (CTXW + 1)
  ) u_div0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dv_ctl),
    .num_i  (num0d_q),
    .den_i  (den0d_q),
    .side_i ({ok0d_q, ctxd_q}),
    .vld_o  (dv_vld),
    .quo_o  (tq0),
    .side_o (dv0_side)
  );

  cbb_div #(
    .NW (NW),
    .QW (F),
    .SW (1)
  ) u_div1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dv_ctl),
    .num_i  (num1d_q),
    .den_i  (den1d_q),
    .side_i (ok1d_q),
    .vld_o  (),
    .quo_o  (tq1),
    .side_o (dv1_ok)
  );

  // curve value at both candidates
  cbb_pkg::pipe_ctl_t hn_ctl;
  logic signed [KW-1:0] k0v, k1v, k2v;
  logic signed [C-1:0]  p0v;
  logic                 hn_vld;
  logic signed [C-1:0]  val0, val1;
  logic [2*C:0]         hn0_side;
  logic                 hn1_ok;

  assign hn_ctl = '{en: ctl_i.en, vld: dv_vld};
  assign k0v    = $signed(dv0_side[CTXW-1 -: KW]);
  assign k1v    = $signed(dv0_side[CTXW-KW-1 -: KW]);
  assign k2v    = $signed(dv0_side[CTXW-2*KW-1 -: KW]);
  assign p0v    = $signed(dv0_side[3*C-1 -: C]);

  cbb_horner #(
    .C  (C),
    .F  (F),
    .SW (2 * C + 1)
  ) u_horner0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (hn_ctl),
    .k0_i   (k0v),
    .k1_i   (k1v),
    .k2_i   (k2v),
    .p0_i   (p0v),
    .tq_i   (tq0),
    .side_i ({dv0_side[CTXW], dv0_side[2*C-1:0]}),
    .vld_o  (hn_vld),
    .val_o  (val0),
    .side_o (hn0_side)
  );

  cbb_horner #(
    .C  (C),
    .F  (F),
    .SW (1)
  ) u_horner1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (hn_ctl),
    .k0_i   (k0v),
    .k1_i   (k1v),
    .k2_i   (k2v),
    .p0_i   (p0v),
    .tq_i   (tq1),
    .side_i (dv1_ok),
    .vld_o  (),
    .val_o  (val1),
    .side_o (hn1_ok)
  );

  // widen the end-point box by the accepted extrema
  logic signed [C-1:0] mne, mxe, mn_d, mx_d;
  logic                vo_q;
  logic signed [C-1:0] mn_q, mx_q;

  assign mne = $signed(hn0_side[2*C-1:C]);
  assign mxe = $signed(hn0_side[C-1:0]);

  always_comb begin
    mn_d = mne;
    mx_d = mxe;
    if (hn0_side[2*C] && (val0 < mn_d)) mn_d = val0;
    if (hn0_side[2*C] && (val0 > mx_d)) mx_d = val0;
    if (hn1_ok && (val1 < mn_d)) mn_d = val1;
    if (hn1_ok && (val1 > mx_d)) mx_d = val1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (ctl_i.en) begin
      vo_q <= hn_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      mn_q <= mn_d;
      mx_q <= mx_d;
    end
  end

  assign vld_o = vo_q;
  assign mn_o  = mn_q;
  assign mx_o  = mx_q;

endmodule

>>> src/cubic_bezier_exact_aabb_core.sv
// Exact axis-aligned box of a 2-D cubic bezier curve, signed fixed-point coordinates.
// A fully pipelined datapath: one curve enters every clock while the pipeline is not frozen.
// Its stages come from the square root (one bit per stage, COORD_BITS+2 stages),
// the divider for t (T_FRAC_BITS stages) and the three two-stage horner steps,
// plus coefficient, product, discriminant, root test and box stages. The last
// stage is the output register; when it holds an item that is not taken the whole
// pipeline freezes and s_axis_tready drops in the same cycle. Both axes run side by
// side in lock step.
// Depends on cbb_pkg and cbb_axis.
module cubic_bezier_exact_aabb_core #(
  parameter int COORD_BITS  = 24,
  parameter int T_FRAC_BITS = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y from the lowest bit up
  input  logic [((8*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // min_x, min_y, max_x, max_y from the lowest bit up, zero padded
  output logic [((4*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata
);

  localparam int C   = COORD_BITS;
  localparam int ODW = ((4 * COORD_BITS + 7) / 8) * 8;

  cbb_pkg::pipe_ctl_t ctl;
  logic               en;
  logic               vx, vy;
  logic signed [C-1:0] min_x, min_y, max_x, max_y;

  // advance unless the output register holds an item that is not taken
  assign en            = !vx || m_axis_tready;
  assign s_axis_tready = en;
  assign ctl           = '{en: en, vld: s_axis_tvalid};

  cbb_axis #(
    .C (C),
    .F (T_FRAC_BITS)
  ) u_axis_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .p0_i   ($signed(s_axis_tdata[0*C +: C])),
    .p1_i   ($signed(s_axis_tdata[2*C +: C])),
    .p2_i   ($signed(s_axis_tdata[4*C +: C])),
    .p3_i   ($signed(s_axis_tdata[6*C +: C])),
    .vld_o  (vx),
    .mn_o   (min_x),
    .mx_o   (max_x)
  );

  cbb_axis #(
    .C (C),
    .F (T_FRAC_BITS)
  ) u_axis_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .p0_i   ($signed(s_axis_tdata[1*C +: C])),
    .p1_i   ($signed(s_axis_tdata[3*C +: C])),
    .p2_i   ($signed(s_axis_tdata[5*C +: C])),
    .p3_i   ($signed(s_axis_tdata[7*C +: C])),
    .vld_o  (vy),
    .mn_o   (min_y),
    .mx_o   (max_y)
  );

  assign m_axis_tvalid = vx;
  assign m_axis_tdata  = ODW'({max_y, max_x, min_y, min_x});

  // both axis pipelines must carry the same items in the same slots
  assert property (@(posedge clk_i) disable iff (!rst_ni) vx == vy)
    else $error("axis pipelines out of step");

  // a finished box is never inverted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (min_x <= max_x) && (min_y <= max_y))
    else $error("box minimum above maximum");

endmodule

>>> tb/tb_top.sv
// testbench for cubic_bezier_exact_aabb_core: directed and random curves streamed in,
// boxes checked against an in-bench bit-exact box predictor; depends on the core only
module tb_top;

  localparam int CB = 24;
  localparam int TF = 24;
  localparam int IN_W  = 8 * CB;
  localparam int OUT_W = 4 * CB;

  class box_scoreboard;
    logic [OUT_W-1:0] boxes_due[$];
    int mismatches;
    int boxes_seen;

    function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // widen the box with the curve value at k0/d when that lies strictly inside (0,1)
    function automatic void widen(longint k0, longint d, longint p0, longint k1,
                                  longint k2, inout longint mn, inout longint mx);
      longint unsigned a0, ad, tq;
      logic signed [127:0] acc, t;
      longint q;
      if (d == 0 || k0 == 0) return;
      if ((k0 < 0) != (d < 0)) return;
      a0 = k0 < 0 ? -k0 : k0;
      ad = d < 0 ? -d : d;
      if (a0 >= ad) return;
      tq = (a0 << TF) / ad;
      t = {64'd0, tq};
      acc = 128'(signed'(k2));
      acc = acc * t + (128'(signed'(3 * k1)) <<< TF);
      acc = acc * t + (128'(signed'(3 * k0)) <<< (2 * TF));
      acc = acc * t + (128'(signed'(p0)) <<< (3 * TF));
      q = longint'(acc >>> (3 * TF));
      if (q < mn) mn = q;
      if (q > mx) mx = q;
    endfunction

    function automatic void axis_extent(longint p0, longint p1, longint p2, longint p3,
                                        output longint mn, output longint mx);
      longint k0, k1, k2, h, s;
      k0 = p1 - p0;
      k1 = p0 - 2 * p1 + p2;
      k2 = -p0 + 3 * p1 - 3 * p2 + p3;
      h = k1 * k1 - k0 * k2;
      mn = p0 < p3 ? p0 : p3;
      mx = p0 > p3 ? p0 : p3;
      if (h <= 0) return;
      s = longint'(root_floor(h));
      widen(k0, -k1 - s, p0, k1, k2, mn, mx);
      widen(k0, -k1 + s, p0, k1, k2, mn, mx);
    endfunction

    function automatic void note_curve(logic [IN_W-1:0] d);
      longint c[8];
      longint mnx, mxx, mny, mxy;
      for (int i = 0; i < 8; i++) c[i] = longint'(signed'(d[CB*i +: CB]));
      axis_extent(c[0], c[2], c[4], c[6], mnx, mxx);
      axis_extent(c[1], c[3], c[5], c[7], mny, mxy);
      boxes_due.insert(boxes_due.size(),
                       {mxy[CB-1:0], mxx[CB-1:0], mny[CB-1:0], mnx[CB-1:0]});
    endfunction

    function automatic void check_box(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      boxes_seen++;
      if (boxes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected box %h", got);
        return;
      end
      want = boxes_due.pop_front();
      for (int f = 0; f < 4; f++) begin
        if (got[CB*f +: CB] !== want[CB*f +: CB]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("box %0d field %0d: expected %h got %h", boxes_seen, f,
                     want[CB*f +: CB], got[CB*f +: CB]);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  box_scoreboard sb = new();
  bit steady = 1'b0;   // no idling on either side while set
  int quiet_cycles = 0;
  int curves_sent = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cubic_bezier_exact_aabb_core #(.COORD_BITS(CB), .T_FRAC_BITS(TF)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_box(m_axis_tdata);
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= steady || ($urandom_range(99) >= 38);
  end

  // tvalid stays up after an accepted item; the next call may drop it, a drain does
  task automatic send_curve(logic [IN_W-1:0] d);
    while (!steady && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_curve(d);
    curves_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_points(int a0, int b0, int a1, int b1, int a2, int b2, int a3, int b3);
    send_curve({b3[CB-1:0], a3[CB-1:0], b2[CB-1:0], a2[CB-1:0],
                b1[CB-1:0], a1[CB-1:0], b0[CB-1:0], a0[CB-1:0]});
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.boxes_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic int coord(int span);
    int v;
    v = $urandom_range(2 * span) - span;
    return v;
  endfunction

  initial begin
    logic [IN_W-1:0] d;
    int lo, hi, mode, s;
    lo = -8388608;
    hi = 8388607;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes, straight lines, interior extremes, zero first difference, flat discriminant
    send_points(0, 0, 0, 0, 0, 0, 0, 0);
    send_points(hi, hi, hi, hi, hi, hi, hi, hi);
    send_points(lo, lo, lo, lo, lo, lo, lo, lo);
    send_points(lo, hi, hi, lo, lo, hi, hi, lo);
    send_points(hi, lo, lo, hi, hi, lo, lo, hi);
    send_points(lo, lo, hi, hi, hi, hi, lo, lo);
    send_points(0, 0, hi, lo, lo, hi, 0, 0);
    send_points(0, 0, 256, 256, 512, 512, 768, 768);
    send_points(0, 0, 0, 0, 1000, 1000, 0, 0);
    send_points(0, 0, 0, 5000, 3000, 5000, 3000, 0);
    send_points(0, 0, 3000, 3000, 0, 0, 3000, 3000);
    send_points(0, 0, 100, 100, 200, 200, 300, 300);
    send_points(-1, -1, 1, 1, -1, -1, 1, 1);
    send_points(0, 0, 256, 0, 256, 0, 0, 0);
    send_points(0, 0, 1, -1, 0, 0, 0, 0);
    send_points(hi, 0, lo, 0, hi, 0, lo, 0);
    send_points(1, 2, 3, 4, 5, 6, 7, 8);
    send_points(-4096, 77, 9000, -1300, -9000, 1300, 4096, -77);
    for (int i = 0; i < 4; i++) begin
      d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      send_curve(d);
      send_curve(~d);
    end

    // hold the sender until the pipe has emptied
    wait_drained();

    for (int n = 0; n < 500; n++) begin
      steady = (n >= 200 && n < 300);
      mode = $urandom_range(9);
      if (mode < 3) begin
        d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
        s = (mode < 6) ? 4000 : (mode < 8) ? 400000 : 8388607;
        for (int i = 0; i < 8; i++) begin
          lo = coord(s);
          d[CB*i +: CB] = lo[CB-1:0];
        end
        if (mode == 9) d[CB*2 +: CB] = d[CB*0 +: CB];
      end
      send_curve(d);
    end
    steady = 1'b0;

    wait_drained();
    repeat (80) @(posedge clk_i);
    $display("tb_top: %0d curves driven, %0d boxes checked, %0d mismatched fields",
             curves_sent, sb.boxes_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.boxes_due.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
